// ===== rtl/core/sunras_pkg.sv =====
// Shared types, constants and control records of the Sun raster stream decoder.
`default_nettype none

package sunras_pkg;

  localparam logic [31:0] RAS_MAGIC    = 32'h59a6_6a95;
  localparam logic [7:0]  RLE_ESCAPE   = 8'h80;
  localparam logic [7:0]  TYPE_INVALID = 8'hff;
  localparam logic [7:0]  TYPE_RLE     = 8'h02;
  localparam logic [7:0]  DEPTH_MONO   = 8'd1;
  localparam logic [7:0]  DEPTH_ALPHA  = 8'd32;
  localparam int          HdrBytes     = 32;
  localparam logic [4:0]  HDR_LAST     = 5'(HdrBytes - 1);

  // Header word positions (byte count divided by four).
  localparam logic [2:0] WORD_MAGIC  = 3'd0;
  localparam logic [2:0] WORD_WIDTH  = 3'd1;
  localparam logic [2:0] WORD_HEIGHT = 3'd2;
  localparam logic [2:0] WORD_DEPTH  = 3'd3;
  localparam logic [2:0] WORD_TYPE   = 3'd5;
  localparam logic [2:0] WORD_MTYPE  = 3'd6;
  localparam logic [2:0] WORD_MLEN   = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_MAP,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    RLE_PLAIN,
    RLE_COUNT,
    RLE_VALUE
  } rle_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_CMAP   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic {
    ERR_MAGIC = 1'b0,
    ERR_TYPE  = 1'b1
  } err_e;

  // Result payload, last field (out_byte) in the lowest bits.
  typedef struct packed {
    logic        error_code;
    logic [15:0] map_length;
    logic [7:0]  map_type;
    logic [7:0]  image_type;
    logic [7:0]  pixel_depth;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [8:0]  run_length;
    logic [7:0]  out_byte;
  } item_t;

  // Datapath to controller.
  typedef struct packed {
    logic hdr_last;
    logic hdr_error;
    logic map_nonzero;
    logic total_nonzero;
    logic map_last;
    logic bytes_zero;
    logic data_done;
    logic have_item;
    logic out_valid;
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    phase_e phase;
    logic   accept;
    logic   load;
    logic   finished;
    logic   blank;
    logic   restart;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sunras_dpath.sv =====
// Datapath of the Sun raster decoder: header fields, size multiplier, RLE and output register.
`default_nettype none

module sunras_dpath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [7:0]           byte_i,
  input  sunras_pkg::cmd_t     cmd_i,
  input  wire                  m_tready_i,
  output sunras_pkg::status_t  status_o,
  output sunras_pkg::item_t    item_o,
  output sunras_pkg::kind_e    kind_o,
  output logic                 last_o,
  output logic                 valid_o
);
  import sunras_pkg::*;

  logic [4:0]  hcount_q, hcount_d;
  logic [31:0] word_q, word_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  mtype_q, mtype_d;
  logic [15:0] mrem_q, mrem_d;
  logic [31:0] brem_q, brem_d;
  rle_e        rle_q, rle_d;
  logic [7:0]  pend_q, pend_d;
  logic [1:0]  alpha_q, alpha_d;

  logic [15:0] width_eff;
  logic [23:0] prod1_q;
  logic [20:0] row_bytes;
  logic [36:0] full_total;
  logic [31:0] tot_q;

  item_t       item_d, item_q;
  kind_e       kind_d, kind_q;
  logic        last_q;
  logic        valid_q;

  logic        have;
  logic        hdr_err;
  logic [8:0]  run;
  logic [8:0]  sub;
  logic        drop;

  // Even rounding of the width applies to RLE images only; it wraps at 16 bits.
  assign width_eff = (type_q == TYPE_RLE) ? ((width_q + 16'd1) & 16'hfffe) : width_q;

  // Two-stage size multiplier. Its inputs settle with the type word, so the
  // total is ready long before the last header byte.
  always_ff @(posedge clk_i) begin
    prod1_q <= 24'(width_eff) * 24'(depth_q);
    tot_q   <= (|full_total[36:32]) ? 32'hffff_ffff : full_total[31:0];
  end

  assign row_bytes  = (depth_q == DEPTH_MONO) ? 21'((17'(width_eff) + 17'd7) >> 3)
                                              : prod1_q[23:3];
  assign full_total = 37'(row_bytes) * 37'(height_q);

  always_comb begin
    hcount_d = hcount_q;
    word_d   = word_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    type_d   = type_q;
    mtype_d  = mtype_q;
    mrem_d   = mrem_q;
    brem_d   = brem_q;
    rle_d    = rle_q;
    pend_d   = pend_q;
    alpha_d  = alpha_q;
    item_d   = '0;
    kind_d   = KIND_DATA;
    have     = 1'b0;
    hdr_err  = 1'b0;
    run      = 9'(pend_q) + 9'd1;
    sub      = '0;
    drop     = 1'b0;

    if ({23'd0, run} > brem_q) begin
      run = brem_q[8:0];
    end

    case (cmd_i.phase)
      PH_HEADER: begin
        word_d   = {word_q[23:0], byte_i};
        hcount_d = hcount_q + 5'd1;
        if (hcount_q[1:0] == 2'd3) begin
          case (hcount_q[4:2])
            WORD_MAGIC: begin
              if (word_d != RAS_MAGIC) begin
                hdr_err            = 1'b1;
                have               = 1'b1;
                kind_d             = KIND_ERROR;
                item_d.error_code  = ERR_MAGIC;
              end
            end
            WORD_WIDTH:  width_d  = word_d[15:0];
            WORD_HEIGHT: height_d = word_d[15:0];
            WORD_DEPTH:  depth_d  = word_d[7:0];
            WORD_TYPE: begin
              type_d = word_d[7:0];
              if (word_d[7:0] == TYPE_INVALID) begin
                hdr_err           = 1'b1;
                have              = 1'b1;
                kind_d            = KIND_ERROR;
                item_d.error_code = ERR_TYPE;
              end
            end
            WORD_MTYPE:  mtype_d  = word_d[7:0];
            WORD_MLEN:   mrem_d   = word_d[15:0];
            default: ;
          endcase
        end
        if (hcount_q == HDR_LAST) begin
          brem_d              = tot_q;
          rle_d               = RLE_PLAIN;
          alpha_d             = '0;
          have                = 1'b1;
          kind_d              = KIND_HEADER;
          item_d.image_width  = width_eff;
          item_d.image_height = height_q;
          item_d.pixel_depth  = depth_q;
          item_d.image_type   = type_q;
          item_d.map_type     = mtype_q;
          item_d.map_length   = word_d[15:0];
        end
      end
      PH_MAP: begin
        have            = 1'b1;
        kind_d          = KIND_CMAP;
        item_d.out_byte = byte_i;
        mrem_d          = mrem_q - 16'd1;
      end
      PH_DATA: begin
        if (type_q == TYPE_RLE) begin
          case (rle_q)
            RLE_PLAIN: begin
              if (byte_i != RLE_ESCAPE) begin
                have              = 1'b1;
                item_d.out_byte   = byte_i;
                item_d.run_length = 9'd1;
                sub               = 9'd1;
              end else begin
                rle_d = RLE_COUNT;
              end
            end
            RLE_COUNT: begin
              if (byte_i == 8'd0) begin
                have              = 1'b1;
                item_d.out_byte   = RLE_ESCAPE;
                item_d.run_length = 9'd1;
                sub               = 9'd1;
                rle_d             = RLE_PLAIN;
              end else begin
                pend_d = byte_i;
                rle_d  = RLE_VALUE;
              end
            end
            default: begin
              have              = 1'b1;
              item_d.out_byte   = byte_i;
              item_d.run_length = run;
              sub               = run;
              rle_d             = RLE_PLAIN;
            end
          endcase
        end else begin
          // At 32 bits per pixel the first byte of every four is alpha.
          if (depth_q == DEPTH_ALPHA) begin
            drop    = (alpha_q == 2'd0);
            alpha_d = alpha_q + 2'd1;
          end
          have              = !drop;
          item_d.out_byte   = byte_i;
          item_d.run_length = 9'd1;
          sub               = 9'd1;
        end
        brem_d = brem_q - 32'(sub);
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o               = '0;
    status_o.hdr_last      = (hcount_q == HDR_LAST);
    status_o.hdr_error     = hdr_err;
    status_o.map_nonzero   = (word_d[15:0] != 16'd0);
    status_o.total_nonzero = (tot_q != 32'd0);
    status_o.map_last      = (mrem_q == 16'd1);
    status_o.bytes_zero    = (brem_q == 32'd0);
    status_o.data_done     = (brem_d == 32'd0);
    status_o.have_item     = have;
    status_o.out_valid     = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcount_q <= '0;
      word_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      type_q   <= '0;
      mtype_q  <= '0;
      mrem_q   <= '0;
      brem_q   <= '0;
      rle_q    <= RLE_PLAIN;
      pend_q   <= '0;
      alpha_q  <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.restart) begin
        hcount_q <= '0;
        word_q   <= '0;
        width_q  <= '0;
        height_q <= '0;
        depth_q  <= '0;
        type_q   <= '0;
        mtype_q  <= '0;
        mrem_q   <= '0;
        brem_q   <= '0;
        rle_q    <= RLE_PLAIN;
        pend_q   <= '0;
        alpha_q  <= '0;
      end else begin
        hcount_q <= hcount_d;
        word_q   <= word_d;
        width_q  <= width_d;
        height_q <= height_d;
        depth_q  <= depth_d;
        type_q   <= type_d;
        mtype_q  <= mtype_d;
        mrem_q   <= mrem_d;
        brem_q   <= brem_d;
        rle_q    <= rle_d;
        pend_q   <= pend_d;
        alpha_q  <= alpha_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= cmd_i.blank ? '0 : item_d;
      kind_q <= cmd_i.blank ? KIND_DATA : kind_d;
      last_q <= cmd_i.finished;
    end
  end

  assign item_o  = item_q;
  assign kind_o  = kind_q;
  assign last_o  = last_q;
  assign valid_o = valid_q;

  a_data_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.phase == PH_DATA |-> brem_q != 32'd0)
    else $error("data phase with no image bytes left");

  a_rle_only_in_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rle_q != RLE_PLAIN |-> cmd_i.phase == PH_DATA)
    else $error("pending escape outside the data phase");

  a_count_wrapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.phase == PH_MAP || cmd_i.phase == PH_DATA) |-> hcount_q == 5'd0)
    else $error("header count not wrapped after the header");

endmodule

`default_nettype wire

// ===== rtl/core/sunras_ctrl.sv =====
// Phase controller of the Sun raster decoder: handshake, phase sequencing and end marking.
`default_nettype none

module sunras_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_tvalid_i,
  input  wire                  eof_i,
  input  wire                  m_tready_i,
  input  sunras_pkg::status_t  status_i,
  output logic                 s_tready_o,
  output sunras_pkg::cmd_t     cmd_o
);
  import sunras_pkg::*;

  phase_e phase_q, phase_d;
  logic   accept;
  logic   ends_dp;
  logic   ends;

  assign s_tready_o = !status_i.out_valid || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    ends_dp = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        if (status_i.hdr_error) begin
          ends_dp = 1'b1;
          phase_d = PH_DONE;
        end else if (status_i.hdr_last) begin
          if (status_i.map_nonzero) begin
            phase_d = PH_MAP;
          end else if (status_i.total_nonzero) begin
            phase_d = PH_DATA;
          end else begin
            ends_dp = 1'b1;
            phase_d = PH_DONE;
          end
        end
      end
      PH_MAP: begin
        if (status_i.map_last) begin
          if (status_i.bytes_zero) begin
            ends_dp = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (status_i.data_done) begin
          ends_dp = 1'b1;
          phase_d = PH_DONE;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      phase_d = phase_q;
    end else if (eof_i) begin
      phase_d = PH_HEADER;
    end
  end

  assign ends = ends_dp || (eof_i && phase_q != PH_DONE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.phase    = phase_q;
    cmd_o.accept   = accept;
    cmd_o.load     = accept && (status_i.have_item || ends);
    cmd_o.finished = ends;
    cmd_o.blank    = ends && !status_i.have_item;
    cmd_o.restart  = accept && eof_i;
  end

  a_eof_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eof_i |=> phase_q == PH_HEADER)
    else $error("end of file did not return to the header phase");

  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !eof_i && phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("left the done phase before end of file");

  a_done_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !cmd_o.load)
    else $error("result produced after the file was finished");

endmodule

`default_nettype wire

// ===== rtl/core/sun_raster_stream_decoder.sv =====
// Top level of the Sun raster stream decoder: controller, datapath and stream port packing.
//
// The slave stream carries one byte of a Sun raster file per transfer; s_axis_tlast
// marks the final byte of the file. The master stream returns at most one result
// per input byte: a header summary after the 32nd header byte, an error when the
// magic word or the image type is bad, each colormap byte, and image data items
// (one byte, or one value with a run length for RLE runs). m_axis_tuser gives the
// result kind and m_axis_tlast flags the last result of the file.
// The result of a byte is held in the output register from the cycle after its
// transfer. Throughput is one byte per cycle while the receiver keeps up; the
// header's image size product is formed by a two-stage multiplier during the
// type-to-end-of-header bytes and never holds the stream.
// When the output register is full and m_axis_tready is low, s_axis_tready drops
// until the pending result is taken, so no byte is lost or repeated.
// Reset clears the phase and all header state; the first byte after reset, and
// after every byte marked with tlast, starts a new file.
`default_nettype none

module sun_raster_stream_decoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire         s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] out_byte, [16:8] run_length, [32:17] image_width, [48:33] image_height,
  // [56:49] pixel_depth, [64:57] image_type, [72:65] map_type, [88:73] map_length,
  // [89] error_code, [95:90] zero
  output logic [95:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // finished
);
  import sunras_pkg::*;

  status_t status;
  cmd_t    cmd;
  item_t   item;
  kind_e   kind;
  logic    last;
  logic    valid;

  // The controller owns the handshake and the file phase.
  sunras_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .eof_i      (s_axis_tlast),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // The datapath holds the header fields, the counters and the output register.
  sunras_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (s_axis_tdata),
    .cmd_i      (cmd),
    .m_tready_i (m_axis_tready),
    .status_o   (status),
    .item_o     (item),
    .kind_o     (kind),
    .last_o     (last),
    .valid_o    (valid)
  );

  // The payload record already has out_byte in its lowest bits; pad to whole bytes.
  assign m_axis_tdata  = {6'd0, item};
  assign m_axis_tuser  = kind;
  assign m_axis_tlast  = last;
  assign m_axis_tvalid = valid;

endmodule

`default_nettype wire
